### design/n32a_pkg.sv
// ----------------------------------------------------------------------------
// n32a_pkg
// Shared types, command codes and status codes of the 32-bit natural ALU.
// ----------------------------------------------------------------------------
package n32a_pkg;

    localparam int DivSteps = 32;

    localparam logic [3:0] CMD_AND = 4'd0;
    localparam logic [3:0] CMD_OR  = 4'd1;
    localparam logic [3:0] CMD_NOT = 4'd2;
    localparam logic [3:0] CMD_NEG = 4'd3;
    localparam logic [3:0] CMD_CMP = 4'd4;
    localparam logic [3:0] CMD_ADD = 4'd5;
    localparam logic [3:0] CMD_INC = 4'd6;
    localparam logic [3:0] CMD_SUB = 4'd7;
    localparam logic [3:0] CMD_MUL = 4'd8;
    localparam logic [3:0] CMD_DIV = 4'd9;
    localparam logic [3:0] CMD_MOD = 4'd10;
    localparam logic [3:0] CMD_SHL = 4'd11;
    localparam logic [3:0] CMD_SHR = 4'd12;
    localparam logic [3:0] CMD_ASR = 4'd13;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CARRY     = 3'd1;
    localparam logic [2:0] ST_BORROW    = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ST_MOD_ZERO  = 3'd4;
    localparam logic [2:0] ST_BAD_SHIFT = 3'd5;
    localparam logic [2:0] ST_ONE_WORD  = 3'd6;
    localparam logic [2:0] ST_TWO_WORD  = 3'd7;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] fill_in;
        logic [31:0] spill_in;
        logic [5:0]  shift_dist;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic [2:0]  status;
        logic [1:0]  order;
    } out_item_t;

    // results that are ready after the front stage, plus multiply partials
    typedef struct packed {
        logic [3:0]  command;
        logic        divisor_zero;
        logic [31:0] low;
        logic [31:0] high;
        logic [2:0]  status;
        logic [1:0]  order;
        logic [31:0] pp_ll;
        logic [31:0] pp_lh;
        logic [31:0] pp_hl;
        logic [31:0] pp_hh;
    } side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] divisor;
    } div_t;

endpackage

### design/n32a_chan_if.sv
// ----------------------------------------------------------------------------
// n32a_chan_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface n32a_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/n32a_front.sv
// ----------------------------------------------------------------------------
// n32a_front
// First stage: logic, add, compare and shift results, multiply partials,
// and the divider seed.
// ----------------------------------------------------------------------------
module n32a_front
    import n32a_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid,
    input  in_item_t item,
    output logic     valid_reg,
    output side_t    side_reg,
    output div_t     div_reg
);

    side_t       side_next;
    div_t        div_next;
    logic [32:0] sum;
    logic [31:0] fill;
    logic [63:0] lo_l;
    logic [63:0] hi_l;
    logic [63:0] lo_r;
    logic [63:0] hi_r;

    always_comb
    begin
        sum  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
        fill = (item.command == CMD_ASR) ? {32{item.operand_a[31]}} : item.fill_in;
        lo_l = {item.operand_a, item.fill_in} << item.shift_dist[4:0];
        hi_l = {item.spill_in, item.operand_a} << item.shift_dist[4:0];
        lo_r = {fill, item.operand_a} >> item.shift_dist[4:0];
        hi_r = {item.operand_a, item.spill_in} >> item.shift_dist[4:0];

        side_next              = '0;
        side_next.command      = item.command;
        side_next.divisor_zero = (item.operand_b == 32'd0);
        side_next.pp_ll        = item.operand_a[15:0]  * item.operand_b[15:0];
        side_next.pp_lh        = item.operand_a[15:0]  * item.operand_b[31:16];
        side_next.pp_hl        = item.operand_a[31:16] * item.operand_b[15:0];
        side_next.pp_hh        = item.operand_a[31:16] * item.operand_b[31:16];

        unique case (item.command)
            CMD_AND: side_next.low = item.operand_a & item.operand_b;
            CMD_OR:  side_next.low = item.operand_a | item.operand_b;
            CMD_NOT: side_next.low = ~item.operand_a;
            CMD_NEG: side_next.low = ~item.operand_a + 32'd1;
            CMD_CMP:
            begin
                if (item.operand_a < item.operand_b)
                    side_next.order = ORD_LESS;
                else if (item.operand_a > item.operand_b)
                    side_next.order = ORD_GREATER;
                else
                    side_next.order = ORD_EQUAL;
            end
            CMD_ADD:
            begin
                side_next.low    = sum[31:0];
                side_next.status = sum[32] ? ST_CARRY : ST_OK;
            end
            CMD_INC:
            begin
                side_next.low    = item.operand_a + 32'd1;
                side_next.status = (item.operand_a == 32'hFFFF_FFFF) ? ST_CARRY : ST_OK;
            end
            CMD_SUB:
            begin
                side_next.low    = item.operand_a - item.operand_b;
                side_next.status = (item.operand_b > item.operand_a) ? ST_BORROW : ST_OK;
            end
            CMD_SHL:
            begin
                if (item.shift_dist[5])
                    side_next.status = ST_BAD_SHIFT;
                else
                begin
                    side_next.low  = lo_l[63:32];
                    side_next.high = hi_l[63:32];
                end
            end
            CMD_SHR, CMD_ASR:
            begin
                if (item.shift_dist[5])
                    side_next.status = ST_BAD_SHIFT;
                else
                begin
                    side_next.low  = lo_r[31:0];
                    side_next.high = hi_r[31:0];
                end
            end
            default: ;
        endcase

        div_next.rem     = '0;
        div_next.quo     = item.operand_a;
        div_next.divisor = item.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

endmodule

### design/n32a_div_step.sv
// ----------------------------------------------------------------------------
// n32a_div_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module n32a_div_step
    import n32a_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid,
    input  side_t side,
    input  div_t  div,
    output logic  valid_reg,
    output side_t side_reg,
    output div_t  div_reg
);

    logic [32:0] partial;
    logic [32:0] diff;
    div_t        div_next;

    always_comb
    begin
        partial          = {div.rem, div.quo[31]};
        diff             = partial - {1'b0, div.divisor};
        div_next.divisor = div.divisor;
        if (!diff[32])
        begin
            div_next.rem = diff[31:0];
            div_next.quo = {div.quo[30:0], 1'b1};
        end
        else
        begin
            div_next.rem = partial[31:0];
            div_next.quo = {div.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side;
            div_reg  <= div_next;
        end
    end

endmodule

### design/natural32_alu_unit.sv
// ----------------------------------------------------------------------------
// natural32_alu_unit
// Unsigned 32-bit ALU: logic, add/sub, multiply, divide and fill/spill shifts.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the sink channel "in" (command, operands, fill, spill,
//   shift distance) and each gives one result item on the source channel
//   "out" (low word, high word, status, compare order).
//   The pipeline is 34 register stages deep: one front stage, 32 division
//   steps of one quotient bit each, and the output register. Every command
//   passes through every stage; one item is accepted per cycle unless stalled.
//   The depth is set by the restoring divider, one bit per stage. Multiply
//   partials are formed in the front stage and summed at the output.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in.ready drops; nothing is lost or repeated. While the output
//   register is empty or being taken, every stage advances, so bubbles in
//   the pipeline still let new items in.
//   Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module natural32_alu_unit
    import n32a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    n32a_chan_if.sink   in,
    n32a_chan_if.source out
);

    logic        en;
    logic        v_pipe    [0:DivSteps];
    side_t       side_pipe [0:DivSteps];
    div_t        div_pipe  [0:DivSteps];
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;
    side_t       last;
    logic [63:0] product;

    // advance everything unless a finished result is held by the receiver
    assign en       = !out_valid_reg || out.ready;
    assign in.ready = en;

    n32a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (in.valid),
        .item      (in.data),
        .valid_reg (v_pipe[0]),
        .side_reg  (side_pipe[0]),
        .div_reg   (div_pipe[0])
    );

    for (genvar i = 0; i < DivSteps; i++)
    begin : g_div
        n32a_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (v_pipe[i]),
            .side      (side_pipe[i]),
            .div       (div_pipe[i]),
            .valid_reg (v_pipe[i+1]),
            .side_reg  (side_pipe[i+1]),
            .div_reg   (div_pipe[i+1])
        );
    end

    // pick the final fields; the product is summed from its four partials
    always_comb
    begin
        last    = side_pipe[DivSteps];
        product = {32'd0, last.pp_ll}
                + ({32'd0, last.pp_lh} << 16)
                + ({32'd0, last.pp_hl} << 16)
                + {last.pp_hh, 32'd0};

        out_item_next.result_low  = last.low;
        out_item_next.result_high = last.high;
        out_item_next.status      = last.status;
        out_item_next.order       = last.order;

        unique case (last.command)
            CMD_MUL:
            begin
                out_item_next.result_low  = product[31:0];
                out_item_next.result_high = product[63:32];
                out_item_next.status      = (product[63:32] == 32'd0) ? ST_ONE_WORD
                                                                      : ST_TWO_WORD;
            end
            CMD_DIV:
            begin
                if (last.divisor_zero)
                begin
                    out_item_next.result_low  = '0;
                    out_item_next.result_high = '0;
                    out_item_next.status      = ST_DIV_ZERO;
                end
                else
                begin
                    out_item_next.result_low  = div_pipe[DivSteps].quo;
                    out_item_next.result_high = div_pipe[DivSteps].rem;
                    out_item_next.status      = ST_OK;
                end
            end
            CMD_MOD:
            begin
                out_item_next.result_high = '0;
                if (last.divisor_zero)
                begin
                    out_item_next.result_low = '0;
                    out_item_next.status     = ST_MOD_ZERO;
                end
                else
                begin
                    out_item_next.result_low = div_pipe[DivSteps].rem;
                    out_item_next.status     = ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_pipe[DivSteps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign out.valid = out_valid_reg;
    assign out.data  = out_item_reg;

endmodule

### bench/alu_check.sv
// ----------------------------------------------------------------------------
// alu_check
// Watches both channels of the ALU, computes the result of every accepted
// item and compares each delivered result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module alu_check
    import n32a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    n32a_chan_if      in_ch,
    n32a_chan_if      out_ch,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    out_item_t want_q[$];
    int        err_count = 0;

    function automatic out_item_t alu_result(in_item_t it);
        out_item_t   r;
        logic [63:0] wide;
        logic [31:0] fill;
        int          n;
        r = '0;
        r.status = ST_OK;
        r.order = ORD_LESS;
        n = int'(it.shift_dist);
        fill = it.fill_in;
        unique case (it.command)
            CMD_AND: r.result_low = it.operand_a & it.operand_b;
            CMD_OR:  r.result_low = it.operand_a | it.operand_b;
            CMD_NOT: r.result_low = ~it.operand_a;
            CMD_NEG: r.result_low = -it.operand_a;
            CMD_CMP:
                r.order = (it.operand_a < it.operand_b) ? ORD_LESS :
                          (it.operand_a > it.operand_b) ? ORD_GREATER : ORD_EQUAL;
            CMD_ADD:
            begin
                wide = {32'd0, it.operand_a} + {32'd0, it.operand_b};
                r.result_low = wide[31:0];
                r.status = wide[32] ? ST_CARRY : ST_OK;
            end
            CMD_INC:
            begin
                r.result_low = it.operand_a + 32'd1;
                r.status = (r.result_low == 0) ? ST_CARRY : ST_OK;
            end
            CMD_SUB:
            begin
                r.result_low = it.operand_a - it.operand_b;
                r.status = (it.operand_b > it.operand_a) ? ST_BORROW : ST_OK;
            end
            CMD_MUL:
            begin
                wide = {32'd0, it.operand_a} * {32'd0, it.operand_b};
                r.result_low = wide[31:0];
                r.result_high = wide[63:32];
                r.status = (wide[63:32] == 0) ? ST_ONE_WORD : ST_TWO_WORD;
            end
            CMD_DIV:
                if (it.operand_b == 0) r.status = ST_DIV_ZERO;
                else
                begin
                    r.result_low = it.operand_a / it.operand_b;
                    r.result_high = it.operand_a % it.operand_b;
                end
            CMD_MOD:
                if (it.operand_b == 0) r.status = ST_MOD_ZERO;
                else r.result_low = it.operand_a % it.operand_b;
            CMD_SHL, CMD_SHR, CMD_ASR:
                if (n > 31) r.status = ST_BAD_SHIFT;
                else if (n == 0)
                begin
                    r.result_low = it.operand_a;
                    r.result_high = it.spill_in;
                end
                else if (it.command == CMD_SHL)
                begin
                    r.result_low = (it.operand_a << n) | (fill >> (32 - n));
                    r.result_high = (it.spill_in << n) | (it.operand_a >> (32 - n));
                end
                else
                begin
                    if (it.command == CMD_ASR) fill = {32{it.operand_a[31]}};
                    r.result_low = (it.operand_a >> n) | (fill << (32 - n));
                    r.result_high = (it.spill_in >> n) | (it.operand_a << (32 - n));
                end
            default: ;
        endcase
        return r;
    endfunction

    assign pending    = want_q.size();
    assign fail_count = err_count;

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                want_q.push_back(alu_result(in_ch.data));
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    err_count++;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got.result_low !== want.result_low)
                        $display("%0t: result_low expected %h actual %h",
                                 $time, want.result_low, got.result_low);
                    if (got.result_high !== want.result_high)
                        $display("%0t: result_high expected %h actual %h",
                                 $time, want.result_high, got.result_high);
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got.order !== want.order)
                        $display("%0t: order expected %0d actual %0d",
                                 $time, want.order, got.order);
                    if (got !== want) err_count++;
                end
            end
        end
    end
endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random ALU commands through the unit with random gaps
// on both channels, a long output stall and a full drain pause; the checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
    import n32a_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency   = 34;
    localparam int CycleMax  = 400000;
    localparam int RandItems = 1500;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   hold_out;     // long receiver stall in progress

    n32a_chan_if #(.T(in_item_t))  in_ch ();
    n32a_chan_if #(.T(out_item_t)) out_ch ();

    natural32_alu_unit dut (.clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch));

    alu_check checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: stop a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleMax)
            begin
                $display("FAIL natural32_alu_unit");
                $finish;
            end
        end
    end

    // Pick a gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(0, 15);
            4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            5: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Send one item, then hold valid low for a random gap.
    task automatic send_item(in_item_t it);
        int g;
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        g = gap_len();
        if (g == 0)
            @(negedge clk);
        else
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_op(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
                           logic [31:0] fill, logic [31:0] spill, int n);
        in_item_t it;
        it.command = cmd;
        it.operand_a = a;
        it.operand_b = b;
        it.fill_in = fill;
        it.spill_in = spill;
        it.shift_dist = 6'(n);
        send_item(it);
    endtask

    // Receiver: random hold-off stretches, plus one long hold-off requested
    // by the driver.
    initial
    begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
                out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 25)
            begin
                // drop ready for a random stretch, mostly short
                g = gap_len();
                out_ch.ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        in_item_t it;
        int       w;
        hold_out = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every command at the field extremes and special cases.
        send_op(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0, 0, 0);
        send_op(CMD_OR, 32'h0, 32'h8000_0001, 0, 0, 0);
        send_op(CMD_NOT, 32'h0, 0, 0, 0, 0);
        send_op(CMD_NEG, 32'h0, 0, 0, 0, 0);
        send_op(CMD_NEG, 32'h8000_0000, 0, 0, 0, 0);
        send_op(CMD_CMP, 5, 5, 0, 0, 0);
        send_op(CMD_CMP, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_op(CMD_CMP, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(CMD_ADD, 32'hFFFF_FFFF, 1, 0, 0, 0);
        send_op(CMD_INC, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(CMD_SUB, 0, 1, 0, 0, 0);
        send_op(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_op(CMD_MUL, 32'hFFFF, 32'hFFFF, 0, 0, 0);
        send_op(CMD_DIV, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(CMD_DIV, 32'hFFFF_FFFF, 7, 0, 0, 0);
        send_op(CMD_MOD, 123, 0, 0, 0, 0);
        send_op(CMD_MOD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 0, 0);
        send_op(CMD_SHL, 32'h1234_5678, 0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 0);
        send_op(CMD_SHL, 32'h8765_4321, 0, 32'hF0F0_F0F0, 32'h1111_1111, 31);
        send_op(CMD_SHR, 32'h8765_4321, 0, 32'hFFFF_FFFF, 32'hCAFE_F00D, 1);
        send_op(CMD_SHR, 32'h8765_4321, 0, 32'h0, 32'hFFFF_FFFF, 63);
        send_op(CMD_ASR, 32'h8000_0000, 0, 32'h0, 0, 31);
        send_op(CMD_ASR, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 4);
        send_op(4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32);
        send_op(4'd15, 1, 1, 1, 1, 1);

        for (int i = 0; i < RandItems; i++)
        begin
            // Stall the receiver for a long stretch while items keep coming.
            if (i == 300)
            begin
                hold_out = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            // Pause the sender until every result has come back.
            if (i == 800)
            begin
                in_ch.valid <= 1'b0;
                w = 0;
                while (pending != 0 && w < 100000)
                begin
                    @(negedge clk);
                    w++;
                end
            end
            it.command = 4'($urandom_range(0, 15));
            it.operand_a = rand_word();
            it.operand_b = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
            it.fill_in = rand_word();
            it.spill_in = rand_word();
            it.shift_dist = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(32, 63))
                                                        : 6'($urandom_range(0, 31));
            send_item(it);
        end
        in_ch.valid <= 1'b0;

        w = 0;
        while (pending != 0 && w < 100000)
        begin
            @(negedge clk);
            w++;
        end
        repeat (Latency + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS natural32_alu_unit");
        else
            $display("FAIL natural32_alu_unit");
        $finish;
    end
endmodule

### filelist.f
design/n32a_pkg.sv
design/n32a_chan_if.sv
design/n32a_front.sv
design/n32a_div_step.sv
design/natural32_alu_unit.sv
bench/alu_check.sv
bench/tb_top.sv
